// ===== rtl/asa_pkg.sv =====
// Package for the ADC scan averager: field widths, codes and transaction structs.
// Depends on nothing; imported by rtl/adc_scan_averager.sv.

package asa_pkg;

   // Fixed field widths
   localparam int SAMPLE_W     = 10;
   localparam int CHAN_W       = 3;
   localparam int MUX_W        = 5;
   localparam int COUNT_W      = 3;
   localparam int MUX_SLOTS    = 8;
   localparam int MUX_TABLE_W  = MUX_W * MUX_SLOTS;
   localparam int CSR_INDEX_W  = 1;

   // Defaults for the top-level parameters
   localparam int DEF_SAMPLE_SHIFT = 2;
   localparam int DEF_CHANNELS     = 8;

   // Item operation codes
   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_READ   = 1'b1
   } op_type;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CHANNEL_COUNT = 1'b0,
      CSR_MUX_TABLE     = 1'b1
   } csr_index_type;

   // Input transaction
   typedef struct packed {
      op_type              op;
      logic [SAMPLE_W-1:0] sample;
      logic [CHAN_W-1:0]   read_channel;
      logic                converter_busy;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic [SAMPLE_W-1:0] read_value;
      logic                start_conversion;
      logic [MUX_W-1:0]    mux_select;
      logic                window_done;
      logic [CHAN_W-1:0]   done_channel;
   } rsp_type;

endpackage

// ===== rtl/adc_scan_averager.sv =====
// ADC scan averager top level: scan state, channel average memory, output skid.
// Depends on rtl/asa_pkg.sv.

// The block takes one transaction per cycle while req_stall is low and
// returns one result for each, held in the output register or skid. A sample
// transaction adds to the running window sum. The sample after a full window
// of 2^SAMPLE_SHIFT samples is dropped. Instead it stores the shifted sum as
// the current scan channel's average and advances the scan (wrapping after
// channel_count-1, a bad count acting as 1). A read transaction returns a
// channel's stored average from the average memory, read at acceptance and
// registered with the result, and flags a conversion start when the
// converter is idle. Results pass through an output register backed by one
// skid entry, so one more transaction is taken while a result waits;
// req_stall rises only while the skid entry is occupied. Averages read as zero
// after reset through per-entry valid bits; there is no clearing pass.
// mux_select always reports the mux word of the scan channel after the item.

module adc_scan_averager #(
   parameter int SAMPLE_SHIFT = asa_pkg::DEF_SAMPLE_SHIFT,
   parameter int CHANNELS     = asa_pkg::DEF_CHANNELS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  asa_pkg::req_type                     req_data,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output asa_pkg::rsp_type                     rsp_data,
   // configuration write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  asa_pkg::csr_index_type               csr_index,
   input  logic [asa_pkg::MUX_TABLE_W-1:0]      csr_data
);
   import asa_pkg::*;

   localparam int ACC_W  = SAMPLE_W + SAMPLE_SHIFT;
   localparam int CNT_W  = SAMPLE_SHIFT + 1;
   localparam int ADDR_W = $clog2(CHANNELS);
   localparam logic [CNT_W-1:0]   WINDOW   = CNT_W'(1 << SAMPLE_SHIFT);
   localparam logic [COUNT_W:0]   CHAN_LIM = (COUNT_W+1)'(CHANNELS);

   // Configuration registers
   logic [COUNT_W-1:0]     channel_count_ff;
   logic [MUX_TABLE_W-1:0] mux_table_ff;

   // Scan state
   logic [ACC_W-1:0]  accum_ff,   accum_in;
   logic [CNT_W-1:0]  samples_ff, samples_in;
   logic [CHAN_W-1:0] scan_ff,    scan_in;

   // Average memory and its valid bits
   logic [SAMPLE_W-1:0] avg_mem [CHANNELS];
   logic [CHANNELS-1:0] avg_valid_ff;

   // Output register and skid entry
   logic    out_valid_ff, skid_valid_ff;
   rsp_type out_data_ff,  skid_data_ff;

   logic               accept, out_take, close_window;
   logic               to_out, to_skid, rd_hit;
   logic [COUNT_W:0]   eff_count;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   logic [SAMPLE_W-1:0] avg_in;
   rsp_type            new_info;

   // Result fields with the memory read word filled in
   function automatic rsp_type with_read_value(rsp_type base, logic [SAMPLE_W-1:0] value);
      rsp_type r;
      r            = base;
      r.read_value = value;
      return r;
   endfunction

   // Handshakes
   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign out_take  = out_valid_ff && !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff <= COUNT_W'(1);
         mux_table_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_data[COUNT_W-1:0];
            CSR_MUX_TABLE:     mux_table_ff     <= csr_data;
            default:           ;
         endcase
      end
   end

   // Window accumulation and scan advance
   always_comb begin
      eff_count = ((channel_count_ff == '0) || ({1'b0, channel_count_ff} >= CHAN_LIM))
                  ? (COUNT_W+1)'(1) : {1'b0, channel_count_ff};
      close_window = accept && (req_data.op == OP_SAMPLE) && (samples_ff == WINDOW);
      accum_in   = accum_ff;
      samples_in = samples_ff;
      scan_in    = scan_ff;
      if (accept && (req_data.op == OP_SAMPLE)) begin
         if (samples_ff != WINDOW) begin
            samples_in = samples_ff + CNT_W'(1);
            accum_in   = accum_ff + ACC_W'(req_data.sample);
         end else begin
            accum_in   = '0;
            samples_in = '0;
            if (({1'b0, scan_ff} + (COUNT_W+1)'(1)) < eff_count) begin
               scan_in = scan_ff + CHAN_W'(1);
            end else begin
               scan_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff   <= '0;
         samples_ff <= '0;
         scan_ff    <= '0;
      end else begin
         accum_ff   <= accum_in;
         samples_ff <= samples_in;
         scan_ff    <= scan_in;
      end
   end

   // Average memory write; scan position always stays below CHANNELS
   assign wr_addr = scan_ff[ADDR_W-1:0];
   assign avg_in  = accum_ff[SAMPLE_SHIFT +: SAMPLE_W];

   always_ff @(posedge clock) begin
      if (close_window) begin
         avg_mem[wr_addr] <= avg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_valid_ff <= '0;
      end else if (close_window) begin
         avg_valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Result fields known at acceptance
   assign rd_addr = req_data.read_channel[ADDR_W-1:0];
   assign rd_hit  = (req_data.op == OP_READ)
                    && ({1'b0, req_data.read_channel} < CHAN_LIM)
                    && avg_valid_ff[rd_addr];

   always_comb begin
      new_info                  = '0;
      new_info.start_conversion = (req_data.op == OP_READ) && !req_data.converter_busy;
      new_info.mux_select       = mux_table_ff[scan_in * MUX_W +: MUX_W];
      new_info.window_done      = close_window;
      new_info.done_channel     = close_window ? scan_ff : '0;
   end

   assign to_out  = accept && (!out_valid_ff || out_take);
   assign to_skid = accept && out_valid_ff && !out_take;

   // Output register and skid control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (out_take) begin
               skid_valid_ff <= 1'b0;
            end
         end else if (to_out) begin
            out_valid_ff <= 1'b1;
         end else if (to_skid) begin
            skid_valid_ff <= 1'b1;
         end else if (out_take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload, with the registered memory read
   always_ff @(posedge clock) begin
      if (skid_valid_ff && out_take) begin
         out_data_ff <= skid_data_ff;
      end else if (to_out) begin
         out_data_ff <= with_read_value(new_info, rd_hit ? avg_mem[rd_addr] : '0);
      end
      if (to_skid) begin
         skid_data_ff <= with_read_value(new_info, rd_hit ? avg_mem[rd_addr] : '0);
      end
   end

endmodule
